@@ sv/isc_pkg.sv @@
// Shared types, widths and reset values for the intersection signal controller.
package isc_pkg;

	// Field and register widths
	localparam int CAR_W       = 4;
	localparam int BTN_W       = 2;
	localparam int BRIGHT_W    = 7;
	localparam int LAMP_W      = 3;
	localparam int TPS_W       = 14;
	localparam int FLASH_W     = 11;
	localparam int SEC_W       = 8;
	localparam int IMG_W       = 18;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 14;

	// PWM period in ticks
	localparam int PWM_STEPS_DEF = 100;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TICKS          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PED_WAIT_SECONDS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WALK_SECONDS         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AMBER_SECONDS        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_HOLD_SECONDS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTEST_HOLD_SECONDS = 3'd6;

	// Configuration reset values
	localparam logic [TPS_W-1:0]   RST_TICKS_PER_SECOND     = 14'd10000;
	localparam logic [FLASH_W-1:0] RST_FLASH_TICKS          = 11'd2000;
	localparam logic [SEC_W-1:0]   RST_PED_WAIT_SECONDS     = 8'd5;
	localparam logic [SEC_W-1:0]   RST_WALK_SECONDS         = 8'd10;
	localparam logic [SEC_W-1:0]   RST_AMBER_SECONDS        = 8'd1;
	localparam logic [SEC_W-1:0]   RST_IDLE_HOLD_SECONDS    = 8'd7;
	localparam logic [SEC_W-1:0]   RST_CONTEST_HOLD_SECONDS = 8'd7;

	// Crosswalk sequencing phases
	typedef enum logic [1:0] {
		CW_RED   = 2'd0,
		CW_GREEN = 2'd1,
		CW_BLUE  = 2'd2
	} cw_phase_t;

	// Input request: one timer tick
	typedef struct packed {
		logic [CAR_W-1:0]    car_sensors;
		logic [BTN_W-1:0]    ped_buttons;
		logic [BRIGHT_W-1:0] brightness_pct;
	} in_req_t;

	// Output request: lamp state after the tick
	typedef struct packed {
		logic [LAMP_W-1:0] lamps_one;
		logic [LAMP_W-1:0] lamps_two;
		logic [LAMP_W-1:0] lamps_three;
		logic [LAMP_W-1:0] lamps_four;
		logic [LAMP_W-1:0] walk_lamps_one;
		logic [LAMP_W-1:0] walk_lamps_two;
		logic              idle_led;
		logic              driver_enable_n;
		logic              heartbeat;
	} out_req_t;

	// Timing configuration
	typedef struct packed {
		logic [TPS_W-1:0]   ticks_per_second;
		logic [FLASH_W-1:0] flash_ticks;
		logic [SEC_W-1:0]   ped_wait_seconds;
		logic [SEC_W-1:0]   walk_seconds;
		logic [SEC_W-1:0]   amber_seconds;
		logic [SEC_W-1:0]   idle_hold_seconds;
		logic [SEC_W-1:0]   contest_hold_seconds;
	} cfg_t;

	// Control pass status toward the result register
	typedef struct packed {
		logic [IMG_W-1:0] lamp_image;
		logic             idle;
		logic             heartbeat;
	} core_status_t;

	// Result of one grant recomputation
	typedef struct packed {
		logic [3:0] grant;
		logic       changed;
	} grant_upd_t;

endpackage

@@ sv/isc_timebase.sv @@
// Blue flash period counter and PWM brightness counter with driver enable compare.
module isc_timebase #(
	parameter int PWM_STEPS = isc_pkg::PWM_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [isc_pkg::FLASH_W-1:0]   flash_ticks,
	input  logic [isc_pkg::BRIGHT_W-1:0]  brightness_pct,
	output logic                          flash_phase,
	output logic                          driver_enable_n
);

	localparam int PWM_W = $clog2(PWM_STEPS + 1);
	localparam int CMP_W = (isc_pkg::BRIGHT_W > PWM_W) ? isc_pkg::BRIGHT_W : PWM_W;

	logic [isc_pkg::FLASH_W-1:0] flash_q, flash_n;
	logic                        flash_phase_q, flash_phase_n;
	logic [PWM_W-1:0]            pwm_q, pwm_n;

	// Next counter values for this tick
	always_comb begin
		if (flash_q >= flash_ticks) begin
			flash_phase_n = ~flash_phase_q;
			flash_n       = isc_pkg::FLASH_W'(1);
		end else begin
			flash_phase_n = flash_phase_q;
			flash_n       = flash_q + isc_pkg::FLASH_W'(1);
		end
		if (pwm_q >= PWM_W'(PWM_STEPS))
			pwm_n = PWM_W'(1);
		else
			pwm_n = pwm_q + PWM_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_q       <= isc_pkg::FLASH_W'(1);
			flash_phase_q <= 1'b0;
			pwm_q         <= PWM_W'(1);
		end else if (advance) begin
			flash_q       <= flash_n;
			flash_phase_q <= flash_phase_n;
			pwm_q         <= pwm_n;
		end
	end

	// Blue lamp sees the phase before this tick's toggle
	assign flash_phase     = flash_phase_q;
	// Driver disabled while the PWM count is above brightness
	assign driver_enable_n = CMP_W'(pwm_n) > CMP_W'(brightness_pct);

endmodule

@@ sv/isc_core.sv @@
// Control pass: group grant, crosswalk sequencing, lamp image and second countdowns.
module isc_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  isc_pkg::cfg_t                cfg,
	input  isc_pkg::in_req_t             req,
	input  logic                         flash_phase,
	output isc_pkg::core_status_t        status
);

	localparam int CW_BASE = 12;

	logic [3:0]                  grant_q, grant_n;
	isc_pkg::cw_phase_t          ph_q [2];
	isc_pkg::cw_phase_t          ph_n [2];
	logic                        grp_q, grp_n;
	logic [isc_pkg::SEC_W-1:0]   amber_q, amber_n;
	logic [isc_pkg::SEC_W-1:0]   pw_q, pw_n;
	logic [isc_pkg::SEC_W-1:0]   walk_q, walk_n;
	logic [isc_pkg::SEC_W-1:0]   contest_q, contest_n;
	logic [isc_pkg::SEC_W-1:0]   idle_q, idle_n;
	logic [isc_pkg::TPS_W-1:0]   sub_q, sub_n;
	logic [isc_pkg::IMG_W-1:0]   img_q, img_n;
	logic                        hb_q, hb_n;

	logic                        car_a, car_b, idle_now;
	logic                        rg_c0, rg_c1;
	logic                        ra;
	logic [3:0]                  cw_mask;
	isc_pkg::grant_upd_t         upd;

	// Recompute grants in the fixed order light three, one, two, four
	function automatic isc_pkg::grant_upd_t regrant(logic [3:0] grant, logic c0_green,
			logic c1_green, logic grp);
		isc_pkg::grant_upd_t r;
		logic                want;
		r.grant   = grant;
		r.changed = 1'b0;
		want = !r.grant[1] && !r.grant[3] && !c1_green && !c0_green && !grp;
		r.changed = r.changed | (want != r.grant[2]);
		r.grant[2] = want;
		want = !r.grant[1] && !r.grant[3] && !c0_green && !grp;
		r.changed = r.changed | (want != r.grant[0]);
		r.grant[0] = want;
		want = !r.grant[0] && !r.grant[2] && !c1_green && grp;
		r.changed = r.changed | (want != r.grant[1]);
		r.grant[1] = want;
		want = !r.grant[0] && !r.grant[2] && !c0_green && !c1_green && grp;
		r.changed = r.changed | (want != r.grant[3]);
		r.grant[3] = want;
		return r;
	endfunction

	always_comb begin
		grant_n   = grant_q;
		ph_n[0]   = ph_q[0];
		ph_n[1]   = ph_q[1];
		grp_n     = grp_q;
		amber_n   = amber_q;
		pw_n      = pw_q;
		walk_n    = walk_q;
		contest_n = contest_q;
		idle_n    = idle_q;
		sub_n     = sub_q;
		img_n     = img_q;
		hb_n      = hb_q;
		ra        = 1'b0;
		cw_mask   = 4'h0;

		// Car demand per group
		car_a    = |(req.car_sensors & 4'h5);
		car_b    = |(req.car_sensors & 4'hA);
		idle_now = !car_a && !car_b;
		if (car_a && !car_b) begin
			grp_n     = 1'b0;
			contest_n = '0;
		end
		if (car_b && !car_a) begin
			grp_n     = 1'b1;
			contest_n = '0;
		end
		if (car_a && car_b && contest_q == '0)
			contest_n = cfg.contest_hold_seconds;

		// With cars waiting, grants are settled before the buttons are seen
		rg_c0 = (ph_q[0] == isc_pkg::CW_GREEN);
		rg_c1 = (ph_q[1] == isc_pkg::CW_GREEN);

		// Pedestrian buttons, each taken only while the other crosswalk is red
		if (req.ped_buttons[0] && ph_n[1] == isc_pkg::CW_RED) begin
			ph_n[0] = isc_pkg::CW_BLUE;
			pw_n    = cfg.ped_wait_seconds;
		end
		if (req.ped_buttons[1] && ph_n[0] == isc_pkg::CW_RED) begin
			ph_n[1] = isc_pkg::CW_BLUE;
			pw_n    = cfg.ped_wait_seconds;
		end

		// Idle hold
		if (idle_now) begin
			rg_c0 = (ph_n[0] == isc_pkg::CW_GREEN);
			rg_c1 = (ph_n[1] == isc_pkg::CW_GREEN);
			if (idle_q == '0)
				idle_n = cfg.idle_hold_seconds;
		end else begin
			idle_n = '0;
		end

		// Main grant update; a change restarts amber and the second
		upd     = regrant(grant_n, rg_c0, rg_c1, grp_n);
		grant_n = upd.grant;
		if (upd.changed) begin
			amber_n = cfg.amber_seconds;
			sub_n   = isc_pkg::TPS_W'(1);
		end

		// Vehicle lamps: red-amber going green, amber going red
		for (int i = 0; i < 4; i++) begin
			if (grant_n[i]) begin
				ra = (amber_n != '0) && !img_q[3*i+2];
				img_n[3*i+:3] = {!ra, ra, ra};
			end else begin
				ra = (amber_n != '0) && !img_q[3*i];
				img_n[3*i+:3] = {1'b0, ra, !ra};
			end
		end

		// Crosswalks in order one, two
		for (int c = 0; c < 2; c++) begin
			cw_mask = (c == 0) ? 4'hD : 4'hE;
			case (ph_n[c])
				isc_pkg::CW_GREEN: begin
					if (|(grant_n & cw_mask)) begin
						upd     = regrant(grant_n, ph_n[0] == isc_pkg::CW_GREEN,
							ph_n[1] == isc_pkg::CW_GREEN, grp_n);
						grant_n = upd.grant;
						if (upd.changed)
							sub_n = isc_pkg::TPS_W'(1);
						amber_n = cfg.amber_seconds;
					end else if (amber_n == '0) begin
						if (walk_n != '0) begin
							img_n[CW_BASE+3*c+1] = 1'b1;
							img_n[CW_BASE+3*c]   = 1'b0;
						end else begin
							ph_n[c]              = isc_pkg::CW_RED;
							img_n[CW_BASE+3*c+1] = 1'b0;
							img_n[CW_BASE+3*c]   = 1'b1;
						end
					end
				end
				isc_pkg::CW_BLUE: begin
					if (pw_n != '0) begin
						img_n[CW_BASE+3*c+2] = flash_phase;
					end else begin
						ph_n[c]              = isc_pkg::CW_GREEN;
						walk_n               = cfg.walk_seconds;
						img_n[CW_BASE+3*c+2] = 1'b0;
					end
				end
				default: begin
					img_n[CW_BASE+3*c]   = 1'b1;
					img_n[CW_BASE+3*c+1] = 1'b0;
				end
			endcase
		end

		// Second boundary: countdowns, hold expiry and heartbeat
		if (sub_n >= cfg.ticks_per_second) begin
			hb_n = ~hb_q;
			if (amber_n != '0)
				amber_n = amber_n - isc_pkg::SEC_W'(1);
			if (idle_n != '0) begin
				if (amber_n == '0)
					idle_n = idle_n - isc_pkg::SEC_W'(1);
				if (idle_n == '0)
					grp_n = ~grp_n;
			end
			if (contest_n != '0) begin
				if (amber_n == '0)
					contest_n = contest_n - isc_pkg::SEC_W'(1);
				if (contest_n == '0)
					grp_n = ~grp_n;
			end
			if (pw_n != '0)
				pw_n = pw_n - isc_pkg::SEC_W'(1);
			else if (walk_n != '0)
				walk_n = walk_n - isc_pkg::SEC_W'(1);
			sub_n = isc_pkg::TPS_W'(1);
		end else begin
			sub_n = sub_n + isc_pkg::TPS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grant_q   <= 4'hA;
			ph_q[0]   <= isc_pkg::CW_RED;
			ph_q[1]   <= isc_pkg::CW_RED;
			grp_q     <= 1'b0;
			amber_q   <= '0;
			pw_q      <= '0;
			walk_q    <= '0;
			contest_q <= '0;
			idle_q    <= '0;
			sub_q     <= isc_pkg::TPS_W'(1);
			img_q     <= '0;
			hb_q      <= 1'b0;
		end else if (advance) begin
			grant_q   <= grant_n;
			ph_q[0]   <= ph_n[0];
			ph_q[1]   <= ph_n[1];
			grp_q     <= grp_n;
			amber_q   <= amber_n;
			pw_q      <= pw_n;
			walk_q    <= walk_n;
			contest_q <= contest_n;
			idle_q    <= idle_n;
			sub_q     <= sub_n;
			img_q     <= img_n;
			hb_q      <= hb_n;
		end
	end

	assign status.lamp_image = img_n;
	assign status.idle       = idle_now;
	assign status.heartbeat  = hb_n;

endmodule

@@ sv/intersection_signal_controller.sv @@
// Intersection signal controller top level: request registers, configuration and result register.
// Each input request is one timer tick; the block takes one request every clock while the output
// is not stalled and returns one result request per tick, passing through the input register,
// then the result register. The combinational control pass reads and updates the controller state
// between the two registers. A stalled output holds the result and backs up into the input
// register; there is no start-up clearing pass.
module intersection_signal_controller #(
	parameter int PWM_STEPS = isc_pkg::PWM_STEPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  isc_pkg::in_req_t                in_req,
	output logic                            out_valid,
	input  logic                            out_ready,
	output isc_pkg::out_req_t               out_req,
	input  logic                            cfg_we,
	input  logic [isc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [isc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	isc_pkg::cfg_t          cfg_q;
	isc_pkg::in_req_t       req_s1;
	logic                   valid_s1;
	isc_pkg::out_req_t      out_req_q;
	logic                   out_valid_q;
	logic                   advance;
	logic                   flash_phase;
	logic                   driver_enable_n;
	isc_pkg::core_status_t  status;
	isc_pkg::out_req_t      result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_second     <= isc_pkg::RST_TICKS_PER_SECOND;
			cfg_q.flash_ticks          <= isc_pkg::RST_FLASH_TICKS;
			cfg_q.ped_wait_seconds     <= isc_pkg::RST_PED_WAIT_SECONDS;
			cfg_q.walk_seconds         <= isc_pkg::RST_WALK_SECONDS;
			cfg_q.amber_seconds        <= isc_pkg::RST_AMBER_SECONDS;
			cfg_q.idle_hold_seconds    <= isc_pkg::RST_IDLE_HOLD_SECONDS;
			cfg_q.contest_hold_seconds <= isc_pkg::RST_CONTEST_HOLD_SECONDS;
		end else if (cfg_we) begin
			case (cfg_index)
				isc_pkg::CFG_TICKS_PER_SECOND:
					cfg_q.ticks_per_second <= cfg_data[isc_pkg::TPS_W-1:0];
				isc_pkg::CFG_FLASH_TICKS:
					cfg_q.flash_ticks <= cfg_data[isc_pkg::FLASH_W-1:0];
				isc_pkg::CFG_PED_WAIT_SECONDS:
					cfg_q.ped_wait_seconds <= cfg_data[isc_pkg::SEC_W-1:0];
				isc_pkg::CFG_WALK_SECONDS:
					cfg_q.walk_seconds <= cfg_data[isc_pkg::SEC_W-1:0];
				isc_pkg::CFG_AMBER_SECONDS:
					cfg_q.amber_seconds <= cfg_data[isc_pkg::SEC_W-1:0];
				isc_pkg::CFG_IDLE_HOLD_SECONDS:
					cfg_q.idle_hold_seconds <= cfg_data[isc_pkg::SEC_W-1:0];
				isc_pkg::CFG_CONTEST_HOLD_SECONDS:
					cfg_q.contest_hold_seconds <= cfg_data[isc_pkg::SEC_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the tick in the input register advances when the result slot frees up
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			req_s1 <= in_req;
	end

	// Control pass
	isc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.cfg         (cfg_q),
		.req         (req_s1),
		.flash_phase (flash_phase),
		.status      (status)
	);

	// Flash and PWM counters
	isc_timebase #(
		.PWM_STEPS (PWM_STEPS)
	) u_timebase (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.flash_ticks     (cfg_q.flash_ticks),
		.brightness_pct  (req_s1.brightness_pct),
		.flash_phase     (flash_phase),
		.driver_enable_n (driver_enable_n)
	);

	// Result assembly
	always_comb begin
		result.lamps_one       = status.lamp_image[2:0];
		result.lamps_two       = status.lamp_image[5:3];
		result.lamps_three     = status.lamp_image[8:6];
		result.lamps_four      = status.lamp_image[11:9];
		result.walk_lamps_one  = status.lamp_image[14:12];
		result.walk_lamps_two  = status.lamp_image[17:15];
		result.idle_led        = status.idle;
		result.driver_enable_n = driver_enable_n;
		result.heartbeat       = status.heartbeat;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_req_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_req_q;

endmodule
